@@ design/hierarchical_timer_wheel_core_assert.svh @@
`ifndef HIERARCHICAL_TIMER_WHEEL_CORE_ASSERT_SVH
`define HIERARCHICAL_TIMER_WHEEL_CORE_ASSERT_SVH
// Assertion helpers; clk and rst_n must be visible where they are used.
`define HTW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/htw_pkg.sv @@
package htw_pkg;

    localparam int SLOT_BITS       = 6;
    localparam int SLOTS_PER_LEVEL = 1 << SLOT_BITS;
    localparam int LEVELS          = 4;
    localparam int LVL_W           = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NSLOTS          = LEVELS * SLOTS_PER_LEVEL;
    localparam int SIDX_W          = LVL_W + SLOT_BITS;
    localparam int TICK_MS         = 10;
    localparam int POOL_SIZE       = 64;
    localparam int PIDX_W          = $clog2(POOL_SIZE);
    localparam int HANDLE_W        = 6;

    // floor(2^32 / TICK_MS); the quotient estimate is low by at most one
    localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / TICK_MS);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef struct packed {
        logic                operation;
        logic [HANDLE_W-1:0] timer_handle;
        logic [31:0]         interval_ms;
        logic                repeat_req;
    } cmd_t;

    typedef struct packed {
        kind_t               kind;
        logic [HANDLE_W-1:0] fired_handle;
        status_t             status;
        logic                last;
    } res_t;

    typedef struct packed {
        logic        repeat_mark;
        logic [31:0] period_ticks;
        logic [31:0] expiry_tick;
    } timer_t;

    typedef struct packed {
        logic              ok;
        logic [SIDX_W-1:0] idx;
    } place_t;

    // Lowest wheel whose reach covers expiry - now, and the slot in it.
    function automatic place_t place_fn(logic [31:0] expiry, logic [31:0] now);
        logic [31:0] span;
        place_t      p;
        span  = expiry - now;
        p.ok  = 1'b0;
        p.idx = '0;
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            if ((span >> (SLOT_BITS * lv)) < 32'(SLOTS_PER_LEVEL)) begin
                p.ok  = 1'b1;
                p.idx = {LVL_W'(lv), SLOT_BITS'(expiry >> (SLOT_BITS * lv))};
            end
        end
        return p;
    endfunction

endpackage

@@ design/htw_ram.sv @@
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/hierarchical_timer_wheel_core.sv @@
// Hierarchical timing wheel for a pool of 64 timers, 4 wheels of 64 slots, 10 ms per tick.
// Command channel: present a word on command and raise start; it is taken at a
// rising edge with start high and busy low. Hold start low or let busy gate it.
// Result channel: result_valid marks a result word for exactly one cycle; the
// receiver cannot stall, so take every word the cycle it shows. last marks the
// final word of a command.
// Add: one word. A rejected add (zero interval, armed timer) answers in the next
// cycle; an accepted add steps through reciprocal multiply, correction, placement
// with tail read, and link write, or answers out of range at placement.
// Tick: checks cascade levels one at a time, opens each nonempty slot, then handles
// each timer cascaded or fired in turn (timer and link read, slot tail read, link
// write). An empty tick answers with a single empty word. The walk is serial, set by
// the one read port on the link and slot memories that each list walk uses.
// Reset: the tick counter clears, every timer reads as unarmed and every slot
// as empty at once through flip-flop valid marks; the memories need no sweep.
module hierarchical_timer_wheel_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  htw_pkg::cmd_t   command,
    output logic            result_valid,
    output htw_pkg::res_t   result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_PLACE,
        S_CASC,
        S_HEAD,
        S_RD,
        S_EVAL,
        S_LINK
    } state_t;

    typedef enum logic [1:0] {
        M_ADD,
        M_CASC,
        M_FIRE
    } mode_t;

    state_t                            state_reg, state_next;
    mode_t                             mode_reg, mode_next;
    logic [31:0]                       tc_reg, tc_next;
    logic [htw_pkg::LVL_W-1:0]         lvl_reg, lvl_next;
    logic [htw_pkg::POOL_SIZE-1:0]     armed_reg, armed_next;
    logic [htw_pkg::NSLOTS-1:0]        svalid_reg, svalid_next;
    logic                              res_valid_reg, res_valid_next;
    htw_pkg::res_t                     res_reg, res_next;

    // Working payload, no reset needed
    logic [htw_pkg::HANDLE_W-1:0]      cur_reg, cur_next;
    logic [htw_pkg::HANDLE_W-1:0]      nxt_reg, nxt_next;
    logic [htw_pkg::HANDLE_W-1:0]      tail_reg, tail_next;
    logic [htw_pkg::SIDX_W-1:0]        tgt_reg, tgt_next;
    logic                              rep_reg, rep_next;
    logic [31:0]                       ms1_reg, ms1_next;
    logic [64:0]                       prod_reg, prod_next;
    logic [31:0]                       ticks_reg, ticks_next;

    // Memory ports
    logic                              tm_we, lk_we, hd_we, tl_we;
    logic [htw_pkg::PIDX_W-1:0]        tm_waddr, tm_raddr, lk_waddr, lk_raddr;
    htw_pkg::timer_t                   tm_wdata, tm_rdata;
    logic [htw_pkg::HANDLE_W-1:0]      lk_wdata, lk_rdata;
    logic [htw_pkg::SIDX_W-1:0]        hd_waddr, hd_raddr, tl_waddr, tl_raddr;
    logic [htw_pkg::HANDLE_W-1:0]      hd_wdata, hd_rdata, tl_wdata, tl_rdata;

    // Cascade lookup per wheel
    logic [htw_pkg::LEVELS-1:0]        casc_hit;
    logic [htw_pkg::SIDX_W-1:0]        casc_idx [htw_pkg::LEVELS];
    logic [htw_pkg::LVL_W:0]           lvl_up;

    logic [32:0]                       q0, q1;
    logic [32:0]                       rem;
    logic [31:0]                       new_exp;
    htw_pkg::place_t                   plc;
    logic                              is_end;
    logic                              do_adv;
    logic [htw_pkg::HANDLE_W-1:0]      adv_handle;
    logic [htw_pkg::SIDX_W-1:0]        fire_idx;

    htw_ram #(.WIDTH($bits(htw_pkg::timer_t)), .DEPTH(htw_pkg::POOL_SIZE)) u_timer_ram (
        .clk   (clk),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wdata (tm_wdata),
        .raddr (tm_raddr),
        .rdata (tm_rdata)
    );

    htw_ram #(.WIDTH(htw_pkg::HANDLE_W), .DEPTH(htw_pkg::POOL_SIZE)) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    htw_ram #(.WIDTH(htw_pkg::HANDLE_W), .DEPTH(htw_pkg::NSLOTS)) u_head_ram (
        .clk   (clk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (hd_raddr),
        .rdata (hd_rdata)
    );

    htw_ram #(.WIDTH(htw_pkg::HANDLE_W), .DEPTH(htw_pkg::NSLOTS)) u_tail_ram (
        .clk   (clk),
        .we    (tl_we),
        .waddr (tl_waddr),
        .wdata (tl_wdata),
        .raddr (tl_raddr),
        .rdata (tl_rdata)
    );

    // A higher wheel is due when every bit below its digit of the tick is zero
    always_comb
    begin
        for (int l = 0; l < htw_pkg::LEVELS; l++)
        begin
            casc_hit[l] = ((tc_reg & 32'((64'd1 << (htw_pkg::SLOT_BITS * l)) - 64'd1)) == 32'd0);
            casc_idx[l] = {htw_pkg::LVL_W'(l),
                           htw_pkg::SLOT_BITS'(tc_reg >> (htw_pkg::SLOT_BITS * l))};
        end
    end

    assign lvl_up   = {1'b0, lvl_reg} + 1'b1;
    assign fire_idx = {htw_pkg::LVL_W'(0), tc_reg[htw_pkg::SLOT_BITS-1:0]};
    assign q0       = prod_reg[64:32];
    assign rem      = {1'b0, ms1_reg} - 33'(q0 * 33'(htw_pkg::TICK_MS));
    assign q1       = (rem >= 33'(htw_pkg::TICK_MS)) ? q0 + 33'd1 : q0;
    assign is_end   = (cur_reg == tail_reg);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        tc_next        = tc_reg;
        lvl_next       = lvl_reg;
        armed_next     = armed_reg;
        svalid_next    = svalid_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        tail_next      = tail_reg;
        tgt_next       = tgt_reg;
        rep_next       = rep_reg;
        ms1_next       = ms1_reg;
        prod_next      = prod_reg;
        ticks_next     = ticks_reg;

        tm_we    = 1'b0;
        tm_waddr = cur_reg[htw_pkg::PIDX_W-1:0];
        tm_wdata = tm_rdata;
        tm_raddr = cur_reg[htw_pkg::PIDX_W-1:0];
        lk_we    = 1'b0;
        lk_waddr = tl_rdata[htw_pkg::PIDX_W-1:0];
        lk_wdata = cur_reg;
        lk_raddr = cur_reg[htw_pkg::PIDX_W-1:0];
        hd_we    = 1'b0;
        hd_waddr = tgt_reg;
        hd_wdata = cur_reg;
        hd_raddr = tgt_reg;
        tl_we    = 1'b0;
        tl_waddr = tgt_reg;
        tl_wdata = cur_reg;
        tl_raddr = tgt_reg;

        new_exp    = tc_reg + ticks_reg;
        plc        = htw_pkg::place_fn(new_exp, tc_reg);
        do_adv     = 1'b0;
        adv_handle = nxt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command.operation == htw_pkg::OP_TICK)
                    begin
                        tc_next    = tc_reg + 32'd1;
                        lvl_next   = '0;
                        state_next = S_CASC;
                    end
                    else if ((7'(command.timer_handle) >= 7'(htw_pkg::POOL_SIZE))
                             || (command.interval_ms == 32'd0)
                             || armed_reg[command.timer_handle[htw_pkg::PIDX_W-1:0]])
                    begin
                        // Reject at once, nothing changes
                        res_valid_next        = 1'b1;
                        res_next.kind         = htw_pkg::KIND_ADD;
                        res_next.fired_handle = command.timer_handle;
                        res_next.status       = htw_pkg::ST_REJECT;
                        res_next.last         = 1'b1;
                    end
                    else
                    begin
                        cur_next   = command.timer_handle;
                        rep_next   = command.repeat_req;
                        ms1_next   = command.interval_ms - 32'd1;
                        mode_next  = M_ADD;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                prod_next  = 65'({33'd0, ms1_reg} * {32'd0, htw_pkg::RECIP});
                state_next = S_FIX;
            end

            S_FIX:
            begin
                ticks_next = q1[31:0] + 32'd1;
                state_next = S_PLACE;
            end

            S_PLACE:
            begin
                tm_we    = 1'b1;
                tm_wdata = '{repeat_mark: rep_reg, period_ticks: ticks_reg,
                             expiry_tick: new_exp};
                if (plc.ok)
                begin
                    tl_raddr   = plc.idx;
                    tgt_next   = plc.idx;
                    state_next = S_LINK;
                end
                else
                begin
                    res_valid_next        = 1'b1;
                    res_next.kind         = htw_pkg::KIND_ADD;
                    res_next.fired_handle = cur_reg;
                    res_next.status       = htw_pkg::ST_RANGE;
                    res_next.last         = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_CASC:
            begin
                // Walk wheels upward while their digit rolls over; stop at the top
                if ((lvl_up < (htw_pkg::LVL_W+1)'(htw_pkg::LEVELS))
                    && casc_hit[lvl_up[htw_pkg::LVL_W-1:0]])
                begin
                    if (svalid_reg[casc_idx[lvl_up[htw_pkg::LVL_W-1:0]]])
                    begin
                        svalid_next[casc_idx[lvl_up[htw_pkg::LVL_W-1:0]]] = 1'b0;
                        hd_raddr   = casc_idx[lvl_up[htw_pkg::LVL_W-1:0]];
                        tl_raddr   = casc_idx[lvl_up[htw_pkg::LVL_W-1:0]];
                        mode_next  = M_CASC;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        lvl_next = lvl_up[htw_pkg::LVL_W-1:0];
                    end
                end
                else if (svalid_reg[fire_idx])
                begin
                    svalid_next[fire_idx] = 1'b0;
                    hd_raddr   = fire_idx;
                    tl_raddr   = fire_idx;
                    mode_next  = M_FIRE;
                    state_next = S_HEAD;
                end
                else
                begin
                    res_valid_next        = 1'b1;
                    res_next.kind         = htw_pkg::KIND_EMPTY;
                    res_next.fired_handle = '0;
                    res_next.status       = htw_pkg::ST_OK;
                    res_next.last         = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_HEAD:
            begin
                cur_next   = hd_rdata;
                tail_next  = tl_rdata;
                state_next = S_RD;
            end

            S_RD:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                nxt_next   = lk_rdata;
                adv_handle = lk_rdata;
                if (mode_reg == M_CASC)
                begin
                    plc = htw_pkg::place_fn(tm_rdata.expiry_tick, tc_reg);
                end
                else
                begin
                    new_exp  = tc_reg + tm_rdata.period_ticks;
                    plc      = htw_pkg::place_fn(new_exp, tc_reg);
                    tm_we    = tm_rdata.repeat_mark;
                    tm_wdata = '{repeat_mark: 1'b1, period_ticks: tm_rdata.period_ticks,
                                 expiry_tick: new_exp};
                end
                if ((mode_reg == M_CASC || tm_rdata.repeat_mark) && plc.ok)
                begin
                    tl_raddr   = plc.idx;
                    tgt_next   = plc.idx;
                    state_next = S_LINK;
                end
                else
                begin
                    // Drop the timer: one-shot fired, or no wheel reaches it
                    armed_next[cur_reg[htw_pkg::PIDX_W-1:0]] = 1'b0;
                    if (mode_reg == M_FIRE)
                    begin
                        res_valid_next        = 1'b1;
                        res_next.kind         = htw_pkg::KIND_FIRED;
                        res_next.fired_handle = cur_reg;
                        res_next.status       = tm_rdata.repeat_mark ? htw_pkg::ST_RANGE
                                                                     : htw_pkg::ST_OK;
                        res_next.last         = is_end;
                    end
                    do_adv = 1'b1;
                end
            end

            S_LINK:
            begin
                // Append cur to slot tgt: link behind the old tail or start a list
                if (svalid_reg[tgt_reg])
                begin
                    lk_we = 1'b1;
                end
                else
                begin
                    hd_we = 1'b1;
                end
                svalid_next[tgt_reg] = 1'b1;
                tl_we = 1'b1;
                unique case (mode_reg)
                    M_ADD:
                    begin
                        armed_next[cur_reg[htw_pkg::PIDX_W-1:0]] = 1'b1;
                        res_valid_next        = 1'b1;
                        res_next.kind         = htw_pkg::KIND_ADD;
                        res_next.fired_handle = cur_reg;
                        res_next.status       = htw_pkg::ST_OK;
                        res_next.last         = 1'b1;
                        state_next            = S_IDLE;
                    end
                    M_FIRE:
                    begin
                        res_valid_next        = 1'b1;
                        res_next.kind         = htw_pkg::KIND_FIRED;
                        res_next.fired_handle = cur_reg;
                        res_next.status       = htw_pkg::ST_OK;
                        res_next.last         = is_end;
                        do_adv                = 1'b1;
                    end
                    M_CASC:
                    begin
                        do_adv = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance along the slot list, or close this slot
        if (do_adv)
        begin
            if (is_end)
            begin
                if (mode_reg == M_CASC)
                begin
                    lvl_next   = lvl_up[htw_pkg::LVL_W-1:0];
                    state_next = S_CASC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            else
            begin
                cur_next   = adv_handle;
                state_next = S_RD;
            end
        end

        if (state_next == S_RD)
        begin
            tm_raddr = cur_next[htw_pkg::PIDX_W-1:0];
            lk_raddr = cur_next[htw_pkg::PIDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_ADD;
            tc_reg        <= '0;
            lvl_reg       <= '0;
            armed_reg     <= '0;
            svalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            tc_reg        <= tc_next;
            lvl_reg       <= lvl_next;
            armed_reg     <= armed_next;
            svalid_reg    <= svalid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        tail_reg  <= tail_next;
        tgt_reg   <= tgt_next;
        rep_reg   <= rep_next;
        ms1_reg   <= ms1_next;
        prod_reg  <= prod_next;
        ticks_reg <= ticks_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ design/htw_checker.sv @@
`include "hierarchical_timer_wheel_core_assert.svh"

module htw_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input htw_pkg::cmd_t command,
    input logic          result_valid,
    input htw_pkg::res_t result
);

    `HTW_ASSERT_IMPLY(a_add_single, result_valid && (result.kind == htw_pkg::KIND_ADD), result.last, "add word not marked last")
    `HTW_ASSERT_IMPLY(a_empty_single, result_valid && (result.kind == htw_pkg::KIND_EMPTY), result.last && (result.status == htw_pkg::ST_OK), "empty tick word malformed")
    `HTW_ASSERT_IMPLY(a_more_pending, result_valid && !result.last, busy, "idle with words still owed")
    `HTW_ASSERT_NEXT(a_zero_reject, start && !busy && (command.operation == htw_pkg::OP_ADD) && (command.interval_ms == 32'd0), result_valid && (result.status == htw_pkg::ST_REJECT), "zero interval not rejected")

endmodule

bind hierarchical_timer_wheel_core htw_checker u_htw_checker (.*);
